// ----- rtl/fpa_pkg.sv -----
`timescale 1ns / 1ps
package fpa_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 8;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_INC = 3'd4,
		OP_DEC = 3'd5,
		OP_MIN = 3'd6,
		OP_MAX = 3'd7
	} op_t;

	// per-transaction control bits passed from front to back
	typedef struct packed {
		logic is_mul;
		logic is_div;
		logic neg;
		logic lt;
		logic eq;
		logic gt;
		logic ovf;
		logic dz;
	} ctrl_t;

	localparam int CTRL_W = $bits(ctrl_t);

endpackage

// ----- rtl/fpa_front.sv -----
`timescale 1ns / 1ps
module fpa_front import fpa_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [2:0]                          op,
	input  logic signed [DATA_WIDTH-1:0]        operand_a,
	input  logic signed [DATA_WIDTH-1:0]        operand_b,
	input  logic                                q_full,
	output logic                                q_push,
	output ctrl_t                               ctrl_s1,
	output logic [DATA_WIDTH-1:0]               res_s1,
	output logic [DATA_WIDTH-FRAC_BITS-1:0]     ip_s1,
	output logic [DATA_WIDTH-1:0]               ma_s1,
	output logic [DATA_WIDTH-1:0]               mb_s1
);

	localparam int W = DATA_WIDTH;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic                vld_s1;
	logic                take;
	logic signed [W-1:0] bb;
	logic signed [W:0]   as;
	logic                as_ovf;
	logic [W-1:0]        as_res;
	logic signed [W-1:0] ash;
	logic                lt, gt, eq;
	ctrl_t               ctrl_d;
	logic [W-1:0]        res_d;

	assign full   = vld_s1 && q_full;
	assign take   = push && !full;
	assign q_push = vld_s1 && !q_full;

	assign lt  = operand_a < operand_b;
	assign gt  = operand_a > operand_b;
	assign eq  = operand_a == operand_b;
	assign ash = operand_a >>> FRAC_BITS;

	always_comb begin
		bb = operand_b;
		if (op_t'(op) == OP_INC || op_t'(op) == OP_DEC)
			bb = W'(1);
		if (op_t'(op) == OP_SUB || op_t'(op) == OP_DEC)
			as = {operand_a[W-1], operand_a} - {bb[W-1], bb};
		else
			as = {operand_a[W-1], operand_a} + {bb[W-1], bb};
		as_ovf = as[W] != as[W-1];
		as_res = as_ovf ? (as[W] ? MINV : MAXV) : as[W-1:0];
	end

	always_comb begin
		ctrl_d     = '0;
		ctrl_d.neg = operand_a[W-1] ^ operand_b[W-1];
		ctrl_d.lt  = lt;
		ctrl_d.eq  = eq;
		ctrl_d.gt  = gt;
		res_d      = '0;
		unique case (op_t'(op))
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				res_d      = as_res;
				ctrl_d.ovf = as_ovf;
			end
			OP_MUL: begin
				ctrl_d.is_mul = 1'b1;
			end
			OP_DIV: begin
				// zero divisor settles here and skips the divider result
				ctrl_d.dz     = operand_b == '0;
				ctrl_d.is_div = operand_b != '0;
			end
			OP_MIN: begin
				res_d = lt ? operand_a : operand_b;
			end
			OP_MAX: begin
				res_d = gt ? operand_a : operand_b;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctrl_s1 <= ctrl_d;
			res_s1  <= res_d;
			ip_s1   <= ash[W-FRAC_BITS-1:0];
			ma_s1   <= operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
			mb_s1   <= operand_b[W-1] ? (~operand_b + 1'b1) : operand_b;
		end
	end

endmodule

// ----- rtl/fpa_queue.sv -----
`timescale 1ns / 1ps
module fpa_queue import fpa_pkg::*; #(
	parameter int WIDTH = CTRL_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             q_full,
	input  logic             rd_en,
	output logic             q_empty,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_wr, do_rd;

	assign q_full  = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_rd)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ----- rtl/fpa_back.sv -----
`timescale 1ns / 1ps
module fpa_back import fpa_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  ctrl_t                               in_ctrl,
	input  logic [DATA_WIDTH-1:0]               in_res,
	input  logic [DATA_WIDTH-FRAC_BITS-1:0]     in_ip,
	input  logic [DATA_WIDTH-1:0]               in_ma,
	input  logic [DATA_WIDTH-1:0]               in_mb,
	output logic                                adv,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [DATA_WIDTH-1:0]        result_raw,
	output logic                                a_less,
	output logic                                a_equal,
	output logic                                a_greater,
	output logic signed [DATA_WIDTH-FRAC_BITS-1:0] integer_part,
	output logic                                overflow,
	output logic                                divide_by_zero
);

	localparam int W   = DATA_WIDTH;
	localparam int NW  = DATA_WIDTH + FRAC_BITS;
	localparam int N   = NW;
	localparam int IPW = DATA_WIDTH - FRAC_BITS;
	localparam int MW  = 2 * DATA_WIDTH + 1;
	localparam int HSH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
	localparam logic [MW-1:0] HALF = (FRAC_BITS > 0) ? (MW'(1) << HSH) : '0;
	localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};

	// one divider step per stage, and one multiplier step in each of the first DATA_WIDTH stages
	logic           vld_sk [0:N];
	ctrl_t          ctrl_sk[0:N];
	logic [W-1:0]   res_sk [0:N];
	logic [IPW-1:0] ip_sk  [0:N];
	logic [W-1:0]   ma_sk  [0:N];
	logic [W-1:0]   mb_sk  [0:N];
	logic [2*W-1:0] acc_sk [0:N];
	logic [W:0]     rem_sk [0:N];
	logic [NW-1:0]  quo_sk [0:N];

	logic           rnd_vld_q;
	ctrl_t          rnd_ctrl_q;
	logic [W-1:0]   rnd_res_q;
	logic [IPW-1:0] rnd_ip_q;
	logic [MW-1:0]  rnd_mag_q;

	logic           out_vld_q;

	assign adv   = !out_vld_q || pop;
	assign empty = !out_vld_q;

	assign vld_sk[0]  = in_vld;
	assign ctrl_sk[0] = in_ctrl;
	assign res_sk[0]  = in_res;
	assign ip_sk[0]   = in_ip;
	assign ma_sk[0]   = in_ma;
	assign mb_sk[0]   = in_mb;
	assign acc_sk[0]  = '0;
	assign rem_sk[0]  = '0;
	assign quo_sk[0]  = '0;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic           nbit;
		logic [W:0]     rs;
		logic           ge;
		logic [2*W-1:0] addend;

		if (NW - 1 - k >= FRAC_BITS) begin : g_nb
			assign nbit = ma_sk[k][NW-1-k-FRAC_BITS];
		end else begin : g_nz
			assign nbit = 1'b0;
		end

		if (k < W) begin : g_mul
			assign addend = mb_sk[k][k] ? ((2*W)'(ma_sk[k]) << k) : '0;
		end else begin : g_nomul
			assign addend = '0;
		end

		assign rs = {rem_sk[k][W-1:0], nbit};
		assign ge = rs >= {1'b0, mb_sk[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k+1] <= 1'b0;
			end else if (adv) begin
				vld_sk[k+1] <= vld_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctrl_sk[k+1] <= ctrl_sk[k];
				res_sk[k+1]  <= res_sk[k];
				ip_sk[k+1]   <= ip_sk[k];
				ma_sk[k+1]   <= ma_sk[k];
				mb_sk[k+1]   <= mb_sk[k];
				acc_sk[k+1]  <= acc_sk[k] + addend;
				rem_sk[k+1]  <= ge ? (rs - {1'b0, mb_sk[k]}) : rs;
				quo_sk[k+1]  <= {quo_sk[k][NW-2:0], ge};
			end
		end
	end

	// round to nearest, halves away from zero
	logic [MW-1:0] mul_mag;
	logic [MW-1:0] div_mag;
	logic          div_up;

	assign mul_mag = ({1'b0, acc_sk[N]} + HALF) >> FRAC_BITS;
	assign div_up  = {rem_sk[N], 1'b0} >= (W+2)'(mb_sk[N]);
	assign div_mag = MW'(quo_sk[N]) + MW'(div_up);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_vld_q <= 1'b0;
		end else if (adv) begin
			rnd_vld_q <= vld_sk[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rnd_ctrl_q <= ctrl_sk[N];
			rnd_res_q  <= res_sk[N];
			rnd_ip_q   <= ip_sk[N];
			rnd_mag_q  <= ctrl_sk[N].is_mul ? mul_mag : div_mag;
		end
	end

	// sign and saturate the mul or div magnitude
	logic [MW-1:0] lim;
	logic          md_ovf;
	logic [W-1:0]  md_res;
	logic [W-1:0]  fin_res;
	logic          fin_ovf;

	assign lim    = (MW'(1) << (W - 1)) - MW'(!rnd_ctrl_q.neg);
	assign md_ovf = rnd_mag_q > lim;

	always_comb begin
		if (md_ovf)
			md_res = rnd_ctrl_q.neg ? MINV : MAXV;
		else if (rnd_ctrl_q.neg)
			md_res = ~rnd_mag_q[W-1:0] + 1'b1;
		else
			md_res = rnd_mag_q[W-1:0];
		if (rnd_ctrl_q.is_mul || rnd_ctrl_q.is_div) begin
			fin_res = md_res;
			fin_ovf = md_ovf;
		end else begin
			fin_res = rnd_res_q;
			fin_ovf = rnd_ctrl_q.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= rnd_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_raw     <= fin_res;
			a_less         <= rnd_ctrl_q.lt;
			a_equal        <= rnd_ctrl_q.eq;
			a_greater      <= rnd_ctrl_q.gt;
			integer_part   <= rnd_ip_q;
			overflow       <= fin_ovf;
			divide_by_zero <= rnd_ctrl_q.dz;
		end
	end

endmodule

// ----- rtl/fixed_point_alu.sv -----
`timescale 1ns / 1ps
// channel  | handshake          | payload
// input    | push / full        | op, operand_a, operand_b
// result   | empty / pop        | result_raw, a_less, a_equal, a_greater,
//          |                    | integer_part, overflow, divide_by_zero
//
// one transaction per cycle is taken and delivered while pop keeps up.
// every transaction crosses the front register, the queue, the shift-add and
// restoring divide pipeline (one bit per stage), the rounding and output registers.
// arst_n clears all valid bits; payload registers are not reset.
// the back pipeline holds when a result waits unpopped; a two-entry queue and
// the front register keep taking input until they fill.
module fixed_point_alu import fpa_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic [2:0]                             op,
	input  logic signed [DATA_WIDTH-1:0]           operand_a,
	input  logic signed [DATA_WIDTH-1:0]           operand_b,
	output logic                                   empty,
	input  logic                                   pop,
	output logic signed [DATA_WIDTH-1:0]           result_raw,
	output logic                                   a_less,
	output logic                                   a_equal,
	output logic                                   a_greater,
	output logic signed [DATA_WIDTH-FRAC_BITS-1:0] integer_part,
	output logic                                   overflow,
	output logic                                   divide_by_zero
);

	localparam int W   = DATA_WIDTH;
	localparam int IPW = DATA_WIDTH - FRAC_BITS;
	localparam int PW  = CTRL_W + 4 * W - FRAC_BITS;

	ctrl_t          f_ctrl, b_ctrl;
	logic [W-1:0]   f_res, f_ma, f_mb, b_res, b_ma, b_mb;
	logic [IPW-1:0] f_ip, b_ip;
	logic           q_full, q_push, q_empty, adv;
	logic [PW-1:0]  q_wdata, q_rdata;

	fpa_front #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.op       (op),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.q_full   (q_full),
		.q_push   (q_push),
		.ctrl_s1  (f_ctrl),
		.res_s1   (f_res),
		.ip_s1    (f_ip),
		.ma_s1    (f_ma),
		.mb_s1    (f_mb)
	);

	assign q_wdata = {f_ctrl, f_res, f_ip, f_ma, f_mb};
	assign {b_ctrl, b_res, b_ip, b_ma, b_mb} = q_rdata;

	fpa_queue #(
		.WIDTH(PW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wdata),
		.q_full (q_full),
		.rd_en  (adv),
		.q_empty(q_empty),
		.rd_data(q_rdata)
	);

	fpa_back #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (!q_empty),
		.in_ctrl       (b_ctrl),
		.in_res        (b_res),
		.in_ip         (b_ip),
		.in_ma         (b_ma),
		.in_mb         (b_mb),
		.adv           (adv),
		.empty         (empty),
		.pop           (pop),
		.result_raw    (result_raw),
		.a_less        (a_less),
		.a_equal       (a_equal),
		.a_greater     (a_greater),
		.integer_part  (integer_part),
		.overflow      (overflow),
		.divide_by_zero(divide_by_zero)
	);

endmodule
